// ===== rtl/linear_blend_skinning_quat_assert.svh =====
// Assertion macros for the skinning block checkers.
`ifndef LINEAR_BLEND_SKINNING_QUAT_ASSERT_SVH
`define LINEAR_BLEND_SKINNING_QUAT_ASSERT_SVH

// Assert an implication that holds in the same cycle.
`define LBSQ_ASSERT_NOW(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("lbsq check failed");

// Assert an implication that holds in the next cycle.
`define LBSQ_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("lbsq check failed");

`endif

// ===== rtl/lbsq_pkg.sv =====
`timescale 1ns / 1ps

package lbsq_pkg;

  localparam int MaxJoints = 64;
  localparam int IdxW      = 6;
  localparam int VecW      = 32;
  localparam int AuxW      = 16;
  localparam int BiasW     = 16;
  localparam int UW        = 36;
  localparam int TW        = 56;
  localparam int RW        = 44;
  localparam int CW        = 48;
  localparam int PsW       = 48;
  localparam int NsW       = 32;

  localparam logic ReqLoad   = 1'b0;
  localparam logic ReqWeight = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StUPos,
    StTPos,
    StUNrm,
    StTNrm,
    StScale,
    StAcc
  } lbsq_state_e;

  typedef struct packed {
    logic load_we;
    logic capture;
    logic rot_u;
    logic rot_t;
    logic sel_nrm;
    logic scale;
    logic acc;
    logic emit;
  } lbsq_cmd_t;

  typedef struct packed {
    logic last;
  } lbsq_sts_t;

  typedef struct packed {
    logic                       req_type;
    logic [IdxW-1:0]            joint_index;
    logic [2:0][VecW-1:0]       vec;
    logic [3:0][AuxW-1:0]       aux;
    logic [BiasW-1:0]           bias;
    logic                       last_weight;
  } lbsq_req_t;

  typedef struct packed {
    logic [2:0][VecW-1:0] pos;
    logic [2:0][AuxW-1:0] nrm;
  } lbsq_rsp_t;

  typedef struct packed {
    logic [2:0][VecW-1:0] pos;
    logic [3:0][AuxW-1:0] rot;
  } lbsq_pose_t;

  function automatic logic signed [PsW-1:0] sat_ps(logic signed [PsW:0] x);
    if (x[PsW] != x[PsW-1]) begin
      return x[PsW] ? {1'b1, {(PsW-1){1'b0}}} : {1'b0, {(PsW-1){1'b1}}};
    end
    return x[PsW-1:0];
  endfunction

  function automatic logic signed [NsW-1:0] sat_ns(logic signed [PsW:0] x);
    if (!(&x[PsW:NsW-1]) && (|x[PsW:NsW-1])) begin
      return x[PsW] ? {1'b1, {(NsW-1){1'b0}}} : {1'b0, {(NsW-1){1'b1}}};
    end
    return x[NsW-1:0];
  endfunction

  function automatic logic signed [VecW-1:0] sat_pos(logic signed [PsW-1:0] x);
    if (!(&x[PsW-1:VecW-1]) && (|x[PsW-1:VecW-1])) begin
      return x[PsW-1] ? {1'b1, {(VecW-1){1'b0}}} : {1'b0, {(VecW-1){1'b1}}};
    end
    return x[VecW-1:0];
  endfunction

  function automatic logic signed [AuxW-1:0] sat_nrm(logic signed [NsW-1:0] x);
    if (!(&x[NsW-1:AuxW-1]) && (|x[NsW-1:AuxW-1])) begin
      return x[NsW-1] ? {1'b1, {(AuxW-1){1'b0}}} : {1'b0, {(AuxW-1){1'b1}}};
    end
    return x[AuxW-1:0];
  endfunction

endpackage

// ===== rtl/lbsq_req_if.sv =====
`timescale 1ns / 1ps

interface lbsq_req_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic        [lbsq_pkg::IdxW-1:0]    joint_index;
  logic signed [lbsq_pkg::VecW-1:0]    vec_x;
  logic signed [lbsq_pkg::VecW-1:0]    vec_y;
  logic signed [lbsq_pkg::VecW-1:0]    vec_z;
  logic signed [lbsq_pkg::AuxW-1:0]    aux_x;
  logic signed [lbsq_pkg::AuxW-1:0]    aux_y;
  logic signed [lbsq_pkg::AuxW-1:0]    aux_z;
  logic signed [lbsq_pkg::AuxW-1:0]    aux_w;
  logic        [lbsq_pkg::BiasW-1:0]   bias;
  logic                                last_weight;

  modport source (output valid, req_type, joint_index, vec_x, vec_y, vec_z,
                  aux_x, aux_y, aux_z, aux_w, bias, last_weight, input ready);
  modport sink (input valid, req_type, joint_index, vec_x, vec_y, vec_z,
                aux_x, aux_y, aux_z, aux_w, bias, last_weight, output ready);
endinterface

interface lbsq_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [lbsq_pkg::VecW-1:0] pos_x;
  logic signed [lbsq_pkg::VecW-1:0] pos_y;
  logic signed [lbsq_pkg::VecW-1:0] pos_z;
  logic signed [lbsq_pkg::AuxW-1:0] nrm_x;
  logic signed [lbsq_pkg::AuxW-1:0] nrm_y;
  logic signed [lbsq_pkg::AuxW-1:0] nrm_z;

  modport source (output valid, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, output ready);
endinterface

// ===== rtl/lbsq_ctrl.sv =====
`timescale 1ns / 1ps

module lbsq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic                req_type_i,
  output logic                req_ready_o,
  input  logic                rsp_ready_i,
  output logic                rsp_valid_o,
  input  lbsq_pkg::lbsq_sts_t sts_i,
  output lbsq_pkg::lbsq_cmd_t cmd_o
);

  lbsq_pkg::lbsq_state_e state_q, state_d;
  logic                  out_vld_q, out_vld_d;
  logic                  fire;
  logic                  accept;

  assign accept = (state_q == lbsq_pkg::StIdle) && req_valid_i;
  assign fire   = !sts_i.last || !out_vld_q || rsp_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      lbsq_pkg::StIdle: begin
        if (accept && (req_type_i == lbsq_pkg::ReqWeight)) state_d = lbsq_pkg::StUPos;
      end
      lbsq_pkg::StUPos:  state_d = lbsq_pkg::StTPos;
      lbsq_pkg::StTPos:  state_d = lbsq_pkg::StUNrm;
      lbsq_pkg::StUNrm:  state_d = lbsq_pkg::StTNrm;
      lbsq_pkg::StTNrm:  state_d = lbsq_pkg::StScale;
      lbsq_pkg::StScale: state_d = lbsq_pkg::StAcc;
      lbsq_pkg::StAcc: begin
        if (fire) state_d = lbsq_pkg::StIdle;
      end
      default: state_d = lbsq_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      lbsq_pkg::StIdle: begin
        req_ready_o   = 1'b1;
        cmd_o.load_we = accept && (req_type_i == lbsq_pkg::ReqLoad);
        cmd_o.capture = accept && (req_type_i == lbsq_pkg::ReqWeight);
      end
      lbsq_pkg::StUPos: cmd_o.rot_u = 1'b1;
      lbsq_pkg::StTPos: cmd_o.rot_t = 1'b1;
      lbsq_pkg::StUNrm: begin
        cmd_o.rot_u   = 1'b1;
        cmd_o.sel_nrm = 1'b1;
      end
      lbsq_pkg::StTNrm: begin
        cmd_o.rot_t   = 1'b1;
        cmd_o.sel_nrm = 1'b1;
      end
      lbsq_pkg::StScale: cmd_o.scale = 1'b1;
      lbsq_pkg::StAcc: begin
        cmd_o.acc  = fire;
        cmd_o.emit = fire && sts_i.last;
      end
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (rsp_ready_i) out_vld_d = 1'b0;
    if (cmd_o.emit) out_vld_d = 1'b1;
  end

  assign rsp_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lbsq_pkg::StIdle;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

// ===== rtl/lbsq_dp.sv =====
`timescale 1ns / 1ps

module lbsq_dp #(
  parameter int MAX_JOINTS = lbsq_pkg::MaxJoints
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lbsq_pkg::lbsq_cmd_t cmd_i,
  input  lbsq_pkg::lbsq_req_t req_i,
  output lbsq_pkg::lbsq_sts_t sts_o,
  output lbsq_pkg::lbsq_rsp_t rsp_o
);

  localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int UW = lbsq_pkg::UW;
  localparam int TW = lbsq_pkg::TW;
  localparam int RW = lbsq_pkg::RW;
  localparam int CW = lbsq_pkg::CW;
  localparam int PsW = lbsq_pkg::PsW;
  localparam int NsW = lbsq_pkg::NsW;
  localparam int VecW = lbsq_pkg::VecW;
  localparam int AuxW = lbsq_pkg::AuxW;
  localparam int BiasW = lbsq_pkg::BiasW;

  lbsq_pkg::lbsq_pose_t mem [MAX_JOINTS];
  lbsq_pkg::lbsq_pose_t rd_q;
  lbsq_pkg::lbsq_req_t  item_q;
  lbsq_pkg::lbsq_rsp_t  rsp_q;
  logic                 jv_q;
  logic                 in_range;
  logic [AW-1:0]        addr;

  logic signed [AuxW-1:0]  q     [4];
  logic signed [VecW-1:0]  v     [3];
  logic signed [UW-1:0]    u_n   [3];
  logic signed [UW-1:0]    u_q   [3];
  logic signed [RW-1:0]    r_n   [3];
  logic signed [RW-1:0]    rp_q  [3];
  logic signed [RW-1:0]    rn_q  [3];
  logic signed [CW-1:0]    pc_n  [3];
  logic signed [CW-1:0]    nc_n  [3];
  logic signed [CW-1:0]    pc_q  [3];
  logic signed [CW-1:0]    nc_q  [3];
  logic signed [PsW-1:0]   ps_n  [3];
  logic signed [NsW-1:0]   ns_n  [3];
  logic signed [PsW-1:0]   psum_q[3];
  logic signed [NsW-1:0]   nsum_q[3];
  logic signed [BiasW:0]   bias_s;

  assign in_range = int'(req_i.joint_index) < MAX_JOINTS;
  assign addr     = AW'(req_i.joint_index);
  assign bias_s   = $signed({1'b0, item_q.bias});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && in_range) begin
      mem[addr] <= '{pos: req_i.vec, rot: req_i.aux};
    end
    if (cmd_i.capture) begin
      rd_q <= mem[addr];
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_q
    assign q[k] = jv_q ? $signed(rd_q.rot[k]) : '0;
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int A = (i + 1) % 3;
    localparam int B = (i + 2) % 3;
    logic signed [VecW+AuxW-1:0] pa, pb;
    logic signed [VecW+AuxW+1:0] du;
    logic signed [UW+AuxW-1:0]   ta, tb, tc;
    logic signed [TW-1:0]        ts, tt;
    logic signed [RW:0]          pj;
    logic signed [RW+BiasW+1:0]  pm, nm;

    assign v[i] = cmd_i.sel_nrm ? VecW'($signed(item_q.aux[i])) : $signed(item_q.vec[i]);

    assign pa  = q[A] * v[B];
    assign pb  = q[B] * v[A];
    assign du  = (VecW+AuxW+2)'(pa) - (VecW+AuxW+2)'(pb) + (VecW+AuxW+2)'(8192);
    assign u_n[i] = UW'(du >>> 14);

    assign ta = q[A] * u_q[B];
    assign tb = q[B] * u_q[A];
    assign tc = q[3] * u_q[i];
    assign ts = TW'(ta) - TW'(tb) + TW'(tc);
    assign tt = (ts <<< 1) + TW'(8192);
    assign r_n[i] = RW'(v[i]) + RW'(tt >>> 14);

    assign pj = (RW+1)'($signed(rd_q.pos[i] & {VecW{jv_q}})) + (RW+1)'(rp_q[i]);
    assign pm = pj * bias_s;
    assign nm = rn_q[i] * bias_s;
    assign pc_n[i] = CW'((pm + (RW+BiasW+2)'(16384)) >>> 15);
    assign nc_n[i] = CW'((nm + (RW+BiasW+2)'(16384)) >>> 15);

    assign ps_n[i] = lbsq_pkg::sat_ps((PsW+1)'(psum_q[i]) + (PsW+1)'(pc_q[i]));
    assign ns_n[i] = lbsq_pkg::sat_ns((PsW+1)'(nsum_q[i]) + (PsW+1)'(nc_q[i]));

    always_ff @(posedge clk_i) begin
      if (cmd_i.rot_u) u_q[i] <= u_n[i];
      if (cmd_i.rot_t && !cmd_i.sel_nrm) rp_q[i] <= r_n[i];
      if (cmd_i.rot_t && cmd_i.sel_nrm) rn_q[i] <= r_n[i];
      if (cmd_i.scale) begin
        pc_q[i] <= pc_n[i];
        nc_q[i] <= nc_n[i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        psum_q[i] <= '0;
        nsum_q[i] <= '0;
      end else if (cmd_i.acc) begin
        psum_q[i] <= item_q.last_weight ? '0 : ps_n[i];
        nsum_q[i] <= item_q.last_weight ? '0 : ns_n[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      for (int k = 0; k < 3; k++) begin
        rsp_q.pos[k] <= lbsq_pkg::sat_pos(ps_n[k]);
        rsp_q.nrm[k] <= lbsq_pkg::sat_nrm(ns_n[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= req_i;
      jv_q   <= in_range;
    end
  end

  assign sts_o.last = item_q.last_weight;
  assign rsp_o      = rsp_q;

endmodule

// ===== rtl/linear_blend_skinning_quat.sv =====
`timescale 1ns / 1ps

// Linear blend skinning with a quaternion pose table. A load request writes one joint's
// pose. A weight request runs a pose memory read, two passes of one shared quaternion
// rotation unit (offset, then normal), a bias scale and an accumulate, and no request
// is taken until it is done. The result of a last weight sits in an output register
// while the next requests are taken; the accumulate of the following last weight waits
// until it is taken. Reading a joint never loaded gives an undefined result.
module linear_blend_skinning_quat #(
  parameter int MAX_JOINTS = lbsq_pkg::MaxJoints
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lbsq_req_if.sink    req_i,
  lbsq_rsp_if.source  rsp_o
);

  lbsq_pkg::lbsq_cmd_t cmd;
  lbsq_pkg::lbsq_sts_t sts;
  lbsq_pkg::lbsq_req_t req;
  lbsq_pkg::lbsq_rsp_t rsp;

  assign req.req_type    = req_i.req_type;
  assign req.joint_index = req_i.joint_index;
  assign req.vec         = {req_i.vec_z, req_i.vec_y, req_i.vec_x};
  assign req.aux         = {req_i.aux_w, req_i.aux_z, req_i.aux_y, req_i.aux_x};
  assign req.bias        = req_i.bias;
  assign req.last_weight = req_i.last_weight;

  lbsq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lbsq_dp #(
    .MAX_JOINTS (MAX_JOINTS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req),
    .sts_o  (sts),
    .rsp_o  (rsp)
  );

  assign rsp_o.pos_x = rsp.pos[0];
  assign rsp_o.pos_y = rsp.pos[1];
  assign rsp_o.pos_z = rsp.pos[2];
  assign rsp_o.nrm_x = rsp.nrm[0];
  assign rsp_o.nrm_y = rsp.nrm[1];
  assign rsp_o.nrm_z = rsp.nrm[2];

endmodule

// ===== rtl/lbsq_checker.sv =====
`timescale 1ns / 1ps
`include "linear_blend_skinning_quat_assert.svh"

module lbsq_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        req_type_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [31:0] pos_x_i
);

  `LBSQ_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i)
  `LBSQ_ASSERT_NEXT(a_rsp_stable, rsp_valid_i && !rsp_ready_i, $stable(pos_x_i))
  `LBSQ_ASSERT_NEXT(a_weight_busy, req_valid_i && req_ready_i && req_type_i, !req_ready_i)
  `LBSQ_ASSERT_NEXT(a_load_silent, req_valid_i && req_ready_i && !req_type_i && !rsp_valid_i, !rsp_valid_i)

endmodule

bind linear_blend_skinning_quat lbsq_sva u_lbsq_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_type_i  (req_i.req_type),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .pos_x_i     (rsp_o.pos_x)
);

// ===== dv/lbsq_checker.sv =====
`timescale 1ns / 1ps

module lbsq_checker (
  input  logic clk_i,
  input  logic rst_ni,
  lbsq_req_if  req_mon,
  lbsq_rsp_if  rsp_mon,
  output int   fail_cnt,
  output int   pending_cnt,
  output int   vertex_cnt
);
  import lbsq_pkg::*;

  typedef struct {
    logic signed [VecW-1:0] px;
    logic signed [VecW-1:0] py;
    logic signed [VecW-1:0] pz;
    logic signed [AuxW-1:0] nx;
    logic signed [AuxW-1:0] ny;
    logic signed [AuxW-1:0] nz;
  } skinned_vtx_t;

  logic signed [VecW-1:0] pose_pos [MaxJoints][3];
  logic signed [AuxW-1:0] pose_rot [MaxJoints][4];
  longint                 pos_acc [3];
  longint                 nrm_acc [3];
  skinned_vtx_t           vtx_q [$];

  localparam longint PosAccMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint PosAccMin = -PosAccMax - 1;

  function automatic longint round_shr(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  // v' = v + 2 * (q x (q x v) + w * (q x v)), rounded per stage
  function automatic void quat_rotate(input longint q[4], input longint v[3],
                                      output longint r[3]);
    longint u[3];
    longint t[3];
    u[0] = round_shr(q[1] * v[2] - q[2] * v[1], 14);
    u[1] = round_shr(q[2] * v[0] - q[0] * v[2], 14);
    u[2] = round_shr(q[0] * v[1] - q[1] * v[0], 14);
    t[0] = q[1] * u[2] - q[2] * u[1] + q[3] * u[0];
    t[1] = q[2] * u[0] - q[0] * u[2] + q[3] * u[1];
    t[2] = q[0] * u[1] - q[1] * u[0] + q[3] * u[2];
    for (int i = 0; i < 3; i++) r[i] = v[i] + round_shr(2 * t[i], 14);
  endfunction

  task automatic apply_request();
    longint q[4];
    longint ofs[3];
    longint nrm[3];
    longint rp[3];
    longint rn[3];
    longint b;
    int     j;
    skinned_vtx_t e;
    j = int'(req_mon.joint_index);
    if (req_mon.req_type == ReqLoad) begin
      pose_pos[j][0] = req_mon.vec_x;
      pose_pos[j][1] = req_mon.vec_y;
      pose_pos[j][2] = req_mon.vec_z;
      pose_rot[j][0] = req_mon.aux_x;
      pose_rot[j][1] = req_mon.aux_y;
      pose_rot[j][2] = req_mon.aux_z;
      pose_rot[j][3] = req_mon.aux_w;
      return;
    end
    for (int i = 0; i < 4; i++) q[i] = longint'(pose_rot[j][i]);
    ofs[0] = longint'(req_mon.vec_x);
    ofs[1] = longint'(req_mon.vec_y);
    ofs[2] = longint'(req_mon.vec_z);
    nrm[0] = longint'(req_mon.aux_x);
    nrm[1] = longint'(req_mon.aux_y);
    nrm[2] = longint'(req_mon.aux_z);
    b = longint'({48'd0, req_mon.bias});
    quat_rotate(q, ofs, rp);
    quat_rotate(q, nrm, rn);
    for (int i = 0; i < 3; i++) begin
      pos_acc[i] = clamp(pos_acc[i] + round_shr((longint'(pose_pos[j][i]) + rp[i]) * b, 15),
                         PosAccMin, PosAccMax);
      nrm_acc[i] = clamp(nrm_acc[i] + round_shr(rn[i] * b, 15),
                         -64'sd2147483648, 64'sd2147483647);
    end
    if (!req_mon.last_weight) return;
    e.px = VecW'(clamp(pos_acc[0], -64'sd2147483648, 64'sd2147483647));
    e.py = VecW'(clamp(pos_acc[1], -64'sd2147483648, 64'sd2147483647));
    e.pz = VecW'(clamp(pos_acc[2], -64'sd2147483648, 64'sd2147483647));
    e.nx = AuxW'(clamp(nrm_acc[0], -64'sd32768, 64'sd32767));
    e.ny = AuxW'(clamp(nrm_acc[1], -64'sd32768, 64'sd32767));
    e.nz = AuxW'(clamp(nrm_acc[2], -64'sd32768, 64'sd32767));
    vtx_q = {vtx_q, e};
    for (int i = 0; i < 3; i++) begin
      pos_acc[i] = 0;
      nrm_acc[i] = 0;
    end
  endtask

  task automatic cmp_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    skinned_vtx_t e;
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        pos_acc[i] = 0;
        nrm_acc[i] = 0;
      end
      vtx_q.delete();
      fail_cnt    <= 0;
      pending_cnt <= 0;
      vertex_cnt  <= 0;
    end else begin
      if (req_mon.valid && req_mon.ready) apply_request();
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (vtx_q.size() == 0) begin
          $error("result with no vertex pending");
          fail_cnt++;
        end else begin
          e = vtx_q.pop_front();
          cmp_field("pos_x", e.px, rsp_mon.pos_x);
          cmp_field("pos_y", e.py, rsp_mon.pos_y);
          cmp_field("pos_z", e.pz, rsp_mon.pos_z);
          cmp_field("nrm_x", e.nx, rsp_mon.nrm_x);
          cmp_field("nrm_y", e.ny, rsp_mon.nrm_y);
          cmp_field("nrm_z", e.nz, rsp_mon.nrm_z);
        end
        vertex_cnt <= vertex_cnt + 1;
      end
      pending_cnt <= vtx_q.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import lbsq_pkg::*;

  localparam int NumRandom  = 1830;
  localparam int IdleLimit  = 4000;
  localparam int HoldCycles = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_cnt;
  int   pending_cnt;
  int   vertex_cnt;
  int   load_cnt = 0;
  int   weight_cnt = 0;
  int   burst_left = 0;
  int   idle_cnt = 0;
  bit   loaded [MaxJoints];
  bit   hold_done = 1'b0;

  lbsq_req_if req_if ();
  lbsq_rsp_if rsp_if ();

  linear_blend_skinning_quat dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  lbsq_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_mon     (req_if),
    .rsp_mon     (rsp_if),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt),
    .vertex_cnt  (vertex_cnt)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    req_if.valid       = 1'b0;
    req_if.req_type    = ReqLoad;
    req_if.joint_index = '0;
    req_if.vec_x       = '0;
    req_if.vec_y       = '0;
    req_if.vec_z       = '0;
    req_if.aux_x       = '0;
    req_if.aux_y       = '0;
    req_if.aux_z       = '0;
    req_if.aux_w       = '0;
    req_if.bias        = '0;
    req_if.last_weight = 1'b0;
    rsp_if.ready       = 1'b0;
  end

  // drop ready on a shifting pattern; hold it off once for a long stretch
  always @(posedge clk_i) begin
    int stall_pct;
    int phase;
    if (rst_ni) begin
      phase = vertex_cnt / 48;
      case (phase % 4)
        0: stall_pct = 0;
        1: stall_pct = 30;
        2: stall_pct = 70;
        default: stall_pct = 10;
      endcase
      if (!hold_done && vertex_cnt >= 200) begin
        hold_done = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= IdleLimit) begin
        $display("** linear_blend_skinning_quat: FAILED **");
        $finish;
      end
    end
  end

  // called at a rising edge; returns at the edge where the request is taken
  task automatic send(logic rt, logic [IdxW-1:0] j, logic signed [VecW-1:0] vx,
                      logic signed [VecW-1:0] vy, logic signed [VecW-1:0] vz,
                      logic signed [AuxW-1:0] ax, logic signed [AuxW-1:0] ay,
                      logic signed [AuxW-1:0] az, logic signed [AuxW-1:0] aw,
                      logic [BiasW-1:0] b, logic lw);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
    end
    burst_left--;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= rt;
    req_if.joint_index <= j;
    req_if.vec_x       <= vx;
    req_if.vec_y       <= vy;
    req_if.vec_z       <= vz;
    req_if.aux_x       <= ax;
    req_if.aux_y       <= ay;
    req_if.aux_z       <= az;
    req_if.aux_w       <= aw;
    req_if.bias        <= b;
    req_if.last_weight <= lw;
    do @(negedge clk_i); while (!req_if.ready);
    @(posedge clk_i);
    if (rt == ReqLoad) begin
      loaded[j] = 1'b1;
      load_cnt++;
    end else begin
      weight_cnt++;
    end
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic signed [VecW-1:0] pick_vec();
    case ($urandom_range(9))
      0, 1: return $urandom;
      2: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000;
    endcase
  endfunction

  function automatic logic signed [AuxW-1:0] pick_aux();
    case ($urandom_range(9))
      0, 1: return AuxW'($urandom);
      2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      default: return AuxW'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic [BiasW-1:0] pick_bias();
    case ($urandom_range(9))
      0: return BiasW'($urandom);
      1: return $urandom_range(1) ? 16'd0 : 16'd32768;
      default: return BiasW'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [IdxW-1:0] pick_loaded();
    logic [IdxW-1:0] j;
    do j = IdxW'($urandom); while (!loaded[j]);
    return j;
  endfunction

  task automatic load_random(logic [IdxW-1:0] j);
    send(ReqLoad, j, pick_vec(), pick_vec(), pick_vec(), pick_aux(), pick_aux(),
         pick_aux(), pick_aux(), BiasW'($urandom), 1'($urandom));
  endtask

  initial begin
    int nw;
    logic [IdxW-1:0] j;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(ReqLoad, 6'd0, 32'sh0001_0000, -32'sh0002_0000, 32'sh0000_8000,
         16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'd0, 1'b0);
    send(ReqLoad, 6'd63, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
         16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'hFFFF, 1'b1);
    send(ReqLoad, 6'd1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
         16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'd0, 1'b0);
    send(ReqLoad, 6'd2, 32'sd0, 32'sd0, 32'sd0,
         16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b1);
    send(ReqWeight, 6'd0, 32'sh0001_0000, 32'sd0, 32'sd0,
         16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'd32768, 1'b1);
    send(ReqWeight, 6'd1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
         16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 1'b0);
    send(ReqWeight, 6'd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
         16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sd0, 16'hFFFF, 1'b1);
    send(ReqWeight, 6'd63, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
         16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'hFFFF, 1'b1);
    send(ReqWeight, 6'd2, 32'sh1234_5678, -32'sh0765_4321, 32'sd5,
         16'sd100, -16'sd200, 16'sd300, 16'sd0, 16'd0, 1'b1);
    send(ReqWeight, 6'd2, 32'sh0003_0000, 32'sh0001_0000, -32'sh0001_0000,
         16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'd16384, 1'b0);
    send(ReqWeight, 6'd0, -32'sh0001_0000, 32'sd1, -32'sd1,
         16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'd16384, 1'b1);
    send(ReqWeight, 6'd1, 32'sd0, 32'sd0, 32'sd0,
         16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd1, 1'b1);
    send(ReqWeight, 6'd63, 32'sh7FFF_FFFF, 32'sd0, 32'sh8000_0000,
         16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0, 16'd32768, 1'b1);
    drain();

    for (int i = 0; i < 8; i++) load_random(IdxW'($urandom));
    while (load_cnt + weight_cnt < NumRandom) begin
      if ($urandom_range(9) == 0) begin
        load_random(IdxW'($urandom));
      end else begin
        nw = $urandom_range(1, 4);
        for (int w = 0; w < nw; w++) begin
          j = pick_loaded();
          send(ReqWeight, j, pick_vec(), pick_vec(), pick_vec(), pick_aux(), pick_aux(),
               pick_aux(), pick_aux(), pick_bias(), 1'(w == nw - 1));
        end
      end
      if ($urandom_range(299) == 0) drain();
    end
    drain();

    $display("covered %0d pose loads and %0d weights, %0d skinned vertices checked",
             load_cnt, weight_cnt, vertex_cnt);
    $display("with extreme poses, out-of-range bias, saturation and a long output stall");
    if (fail_cnt == 0) begin
      $display("** linear_blend_skinning_quat: PASSED **");
    end else begin
      $display("** linear_blend_skinning_quat: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lbsq_pkg.sv
rtl/lbsq_req_if.sv
rtl/lbsq_ctrl.sv
rtl/lbsq_dp.sv
rtl/linear_blend_skinning_quat.sv
rtl/lbsq_checker.sv
dv/lbsq_checker.sv
dv/tb.sv
